>>> src/cic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic_pkg: shared constants and codes for the cloud-in-cell mass deposit core
// Grid geometry, field widths, action and register codes, reset values.
// ----------------------------------------------------------------------------
package cic_pkg;

  // Grid side is a power of two: GRID_SIZE = 2**GRID_LOG2 (1..8)
  localparam int GRID_LOG2  = 6;
  localparam int GRID_SIZE  = 1 << GRID_LOG2;
  localparam int ADDR_W     = 3 * GRID_LOG2;
  localparam int CELL_COUNT = 1 << ADDR_W;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int CIDX_W  = 6;
  localparam int CELL_W  = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int REG_W   = 31;

  // Actions; the unused code behaves as a total read
  localparam logic [ACT_W-1:0] ACT_DEPOSIT    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ_CELL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ_TOTAL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_APPLY_WEIGHT = 2'd2;

  // Reset values
  localparam logic [REG_W-1:0] BOX_LENGTH_RST    = 31'd65536;
  localparam logic [REG_W-1:0] CELLS_PER_LEN_RST = 31'd4194304;

  // 1.0 in Q0.16, one bit wider than a fraction
  localparam logic [16:0] ONE_Q16 = 17'h10000;

endpackage

>>> src/cic_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic_if: valid/ready channels of the mass deposit core
// Deposit/read command channel, result channel and register write channel.
// ----------------------------------------------------------------------------

// Command beat: one deposit or read request
interface cic_dep_if;
  import cic_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [MASS_W-1:0]        mass;
  logic signed [MASS_W-1:0] weight;
  logic [CIDX_W-1:0]        cell_x;
  logic [CIDX_W-1:0]        cell_y;
  logic [CIDX_W-1:0]        cell_z;

  modport source (output valid, action, pos_x, pos_y, pos_z, mass, weight,
                  cell_x, cell_y, cell_z, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, mass, weight,
                  cell_x, cell_y, cell_z, output ready);
endinterface

// Result beat: one per command
interface cic_res_if;
  import cic_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_value;
  logic [CELL_W-1:0]        mass_total;
  logic                     status;

  modport source (output valid, cell_value, mass_total, status, input ready);
  modport sink   (input valid, cell_value, mass_total, status, output ready);
endinterface

// Register write beat
interface cic_cfg_if;
  import cic_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/cic_mass_deposit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic_mass_deposit_core: cloud-in-cell mass deposit on a periodic cubic grid
// Wraps a particle into the box, splits its mass trilinearly over eight
// cells of a single-port grid memory and keeps a saturating mass total.
// ----------------------------------------------------------------------------
// After reset the core sweeps the grid memory to zero, one cell per cycle;
// command ready stays low until the sweep is done, while register writes are
// taken at any time. One command is worked on at a time and ready is low
// while it runs. Every multiply goes through the one shared 32x32
// multiplier: three for the grid coordinates, one for the weighted mass
// (with weighting on), and four per cell; each of the eight cells then
// takes a share combine with the memory read and a read-modify-write. The
// result sits in an output register, so the next command is taken in the
// cycle after a result is loaded, even while that result still waits to be
// taken.
module cic_mass_deposit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  cic_dep_if.sink     dep_i,
  cic_res_if.source   res_o,
  cic_cfg_if.sink     cfg_i
);
  import cic_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_SPLIT_X = 4'd3;
  localparam logic [3:0] S_SPLIT_Y = 4'd4;
  localparam logic [3:0] S_SPLIT_Z = 4'd5;
  localparam logic [3:0] S_WMASS   = 4'd6;
  localparam logic [3:0] S_W1      = 4'd7;
  localparam logic [3:0] S_W2      = 4'd8;
  localparam logic [3:0] S_ML      = 4'd9;
  localparam logic [3:0] S_MH      = 4'd10;
  localparam logic [3:0] S_SHARE   = 4'd11;
  localparam logic [3:0] S_UPD     = 4'd12;
  localparam logic [3:0] S_RDREQ   = 4'd13;
  localparam logic [3:0] S_RDDATA  = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  // Corner order of the eight cells: bit 2 = x, bit 1 = y, bit 0 = z upper
  localparam logic [2:0] CORNER_SEL [8] = '{3'b000, 3'b100, 3'b010, 3'b001,
                                            3'b110, 3'b101, 3'b011, 3'b111};

  localparam logic signed [CELL_W+1:0] CELL_MAX = (CELL_W+2)'(2**(CELL_W-1) - 1);
  localparam logic signed [CELL_W+1:0] CELL_MIN = -(CELL_W+2)'(2**(CELL_W-1));

  typedef struct packed {
    logic             oor;
    logic [REG_W-1:0] val;
  } wrap_t;

  // Wrap one coordinate once into [0, len); flag it beyond one box length
  function automatic wrap_t wrap_coord(logic [POS_W-1:0] raw, logic [REG_W-1:0] len);
    logic signed [POS_W+1:0] xs;
    logic signed [POS_W+1:0] ls;
    logic signed [POS_W+1:0] res;
    wrap_t r;
    xs = {{2{raw[POS_W-1]}}, raw};
    ls = {3'b000, len};
    r.oor = (xs < -ls) || (xs >= (ls <<< 1));
    if (xs < 0) begin
      res = xs + ls;
    end else if (xs >= ls) begin
      res = xs - ls;
    end else begin
      res = xs;
    end
    r.val = res[REG_W-1:0];
    return r;
  endfunction

  // Read index modulo the grid side
  function automatic logic [GRID_LOG2-1:0] read_idx(logic [CIDX_W-1:0] c);
    logic [CIDX_W+1:0] ext;
    ext = {2'b00, c};
    return ext[GRID_LOG2-1:0];
  endfunction

  // Control state
  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [2:0]        cnt_q;
  logic [CELL_W-1:0] total_q;
  logic              out_valid_q;

  // Registers
  logic [REG_W-1:0]  box_len_q;
  logic [REG_W-1:0]  cpl_q;
  logic              apply_wt_q;

  // Command beat
  logic [ACT_W-1:0]  act_q;
  logic [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic [MASS_W-1:0] mass_q, weight_q;
  logic [ADDR_W-1:0] rd_addr_q;

  // Deposit datapath
  logic [REG_W-1:0]     wx_q, wy_q, wz_q;
  logic [GRID_LOG2-1:0] ix_q, iy_q, iz_q;
  logic [15:0]          dx_q, dy_q, dz_q;
  logic [46:0]          mag_q;
  logic                 neg_q;
  logic [16:0]          wab_q;
  logic [16:0]          cw_q;
  logic [48:0]          plo_q;
  logic [31:0]          phi_q;
  logic [CELL_W-1:0]    share_q;
  logic [CELL_W-1:0]    res_cell_q;
  logic                 res_status_q;

  // Output register
  logic [CELL_W-1:0] out_cell_q;
  logic [CELL_W-1:0] out_total_q;
  logic              out_status_q;

  // Grid memory
  logic [CELL_W-1:0] grid_mem [CELL_COUNT];
  logic [CELL_W-1:0] mem_rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem_wdata;

  logic              dep_fire, out_load;
  wrap_t             wrx, wry, wrz;
  logic              any_oor;
  logic [2:0]        sel;
  logic [16:0]       tx, ty, tz, wa, wb, wc;
  logic [GRID_LOG2-1:0] cx, cy, cz;
  logic [ADDR_W-1:0] dep_addr;
  logic [31:0]       wmag;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       share_sum;
  logic signed [CELL_W+1:0] upd_sum;
  logic [CELL_W-1:0] upd_val;
  logic [CELL_W:0]   tot_sum;
  logic [CELL_W-1:0] tot_sat;

  assign dep_fire = dep_i.valid && dep_i.ready;
  assign dep_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || res_o.ready);

  assign res_o.valid      = out_valid_q;
  assign res_o.cell_value = out_cell_q;
  assign res_o.mass_total = out_total_q;
  assign res_o.status     = out_status_q;

  // Wrap check, all three axes side by side
  always_comb begin
    wrx = wrap_coord(pos_x_q, box_len_q);
    wry = wrap_coord(pos_y_q, box_len_q);
    wrz = wrap_coord(pos_z_q, box_len_q);
    any_oor = wrx.oor || wry.oor || wrz.oor;
  end

  // Corner weights and cell address of the current corner
  always_comb begin
    sel = CORNER_SEL[cnt_q];
    tx = ONE_Q16 - {1'b0, dx_q};
    ty = ONE_Q16 - {1'b0, dy_q};
    tz = ONE_Q16 - {1'b0, dz_q};
    wa = sel[2] ? {1'b0, dx_q} : tx;
    wb = sel[1] ? {1'b0, dy_q} : ty;
    wc = sel[0] ? {1'b0, dz_q} : tz;
    cx = sel[2] ? ix_q + 1'b1 : ix_q;
    cy = sel[1] ? iy_q + 1'b1 : iy_q;
    cz = sel[0] ? iz_q + 1'b1 : iz_q;
    dep_addr = {cx, cy, cz};
  end

  // Weight magnitude; the most negative weight maps to 2**31
  assign wmag = weight_q[MASS_W-1] ? (~weight_q + 32'd1) : weight_q;

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      S_SPLIT_X: begin
        mul_a = {1'b0, wx_q};
        mul_b = {1'b0, cpl_q};
      end
      S_SPLIT_Y: begin
        mul_a = {1'b0, wy_q};
        mul_b = {1'b0, cpl_q};
      end
      S_SPLIT_Z: begin
        mul_a = {1'b0, wz_q};
        mul_b = {1'b0, cpl_q};
      end
      S_WMASS: begin
        mul_a = mass_q;
        mul_b = wmag;
      end
      S_W1: begin
        mul_a = {15'd0, wa};
        mul_b = {15'd0, wb};
      end
      S_W2: begin
        mul_a = {15'd0, wab_q};
        mul_b = {15'd0, wc};
      end
      S_ML: begin
        mul_a = mag_q[31:0];
        mul_b = {15'd0, cw_q};
      end
      S_MH: begin
        mul_a = {17'd0, mag_q[46:32]};
        mul_b = {15'd0, cw_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // Share combine, cell update with saturation, total update
  always_comb begin
    share_sum = {phi_q, 32'd0} + {15'd0, plo_q};
    if (neg_q) begin
      upd_sum = {{2{mem_rdata_q[CELL_W-1]}}, mem_rdata_q} - {2'b00, share_q};
    end else begin
      upd_sum = {{2{mem_rdata_q[CELL_W-1]}}, mem_rdata_q} + {2'b00, share_q};
    end
    priority if (upd_sum > CELL_MAX) begin
      upd_val = CELL_MAX[CELL_W-1:0];
    end else if (upd_sum < CELL_MIN) begin
      upd_val = CELL_MIN[CELL_W-1:0];
    end else begin
      upd_val = upd_sum[CELL_W-1:0];
    end
    tot_sum = {1'b0, total_q} + {17'd0, mass_q};
    tot_sat = tot_sum[CELL_W] ? '1 : tot_sum[CELL_W-1:0];
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = upd_val;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = '0;
      end
      S_SHARE: begin
        mem_re   = 1'b1;
        mem_addr = dep_addr;
      end
      S_UPD: begin
        mem_we   = 1'b1;
        mem_addr = dep_addr;
      end
      S_RDREQ: begin
        mem_re   = 1'b1;
        mem_addr = rd_addr_q;
      end
      default: begin
        mem_addr = dep_addr;
      end
    endcase
  end

  // Grid memory, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= grid_mem[mem_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (dep_fire) state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (act_q == ACT_DEPOSIT) begin
          state_d = any_oor ? S_DONE : S_SPLIT_X;
        end else if (act_q == ACT_READ_CELL) begin
          state_d = S_RDREQ;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SPLIT_X: state_d = S_SPLIT_Y;
      S_SPLIT_Y: state_d = S_SPLIT_Z;
      S_SPLIT_Z: state_d = apply_wt_q ? S_WMASS : S_W1;
      S_WMASS:   state_d = S_W1;
      S_W1:      state_d = S_W2;
      S_W2:      state_d = S_ML;
      S_ML:      state_d = S_MH;
      S_MH:      state_d = S_SHARE;
      S_SHARE:   state_d = S_UPD;
      S_UPD:     state_d = (cnt_q == 3'd7) ? S_DONE : S_W1;
      S_RDREQ:   state_d = S_RDDATA;
      S_RDDATA:  state_d = S_DONE;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      box_len_q   <= BOX_LENGTH_RST;
      cpl_q       <= CELLS_PER_LEN_RST;
      apply_wt_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      // corner counter restarts with each command
      if (state_q == S_CHECK) begin
        cnt_q <= '0;
      end else if (state_q == S_UPD) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == S_CHECK && act_q == ACT_DEPOSIT && !any_oor) begin
        total_q <= tot_sat;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // register writes; an index past the list is ignored
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_BOX_LENGTH:    box_len_q  <= cfg_i.data[REG_W-1:0];
          CFG_CELLS_PER_LEN: cpl_q      <= cfg_i.data[REG_W-1:0];
          CFG_APPLY_WEIGHT:  apply_wt_q <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (dep_fire) begin
      act_q     <= dep_i.action;
      pos_x_q   <= dep_i.pos_x;
      pos_y_q   <= dep_i.pos_y;
      pos_z_q   <= dep_i.pos_z;
      mass_q    <= dep_i.mass;
      weight_q  <= dep_i.weight;
      rd_addr_q <= {read_idx(dep_i.cell_x), read_idx(dep_i.cell_y),
                    read_idx(dep_i.cell_z)};
    end
    unique case (state_q)
      S_CHECK: begin
        wx_q         <= wrx.val;
        wy_q         <= wry.val;
        wz_q         <= wrz.val;
        mag_q        <= {15'd0, mass_q};
        neg_q        <= 1'b0;
        res_cell_q   <= '0;
        res_status_q <= (act_q == ACT_DEPOSIT) && any_oor;
      end
      S_SPLIT_X: begin
        ix_q <= mul_p[32 +: GRID_LOG2];
        dx_q <= mul_p[31:16];
      end
      S_SPLIT_Y: begin
        iy_q <= mul_p[32 +: GRID_LOG2];
        dy_q <= mul_p[31:16];
      end
      S_SPLIT_Z: begin
        iz_q <= mul_p[32 +: GRID_LOG2];
        dz_q <= mul_p[31:16];
      end
      S_WMASS: begin
        mag_q <= mul_p[62:16];
        neg_q <= weight_q[MASS_W-1];
      end
      S_W1:     wab_q   <= mul_p[32:16];
      S_W2:     cw_q    <= mul_p[32:16];
      S_ML:     plo_q   <= mul_p[48:0];
      S_MH:     phi_q   <= mul_p[31:0];
      S_SHARE:  share_q <= share_sum[63:16];
      S_RDDATA: res_cell_q <= mem_rdata_q;
      default: ;
    endcase
    if (out_load) begin
      out_cell_q   <= res_cell_q;
      out_total_q  <= total_q;
      out_status_q <= res_status_q;
    end
  end

endmodule

>>> src/cic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic_checker: port-level checks of the mass deposit core
// Busy and sweep behavior, result hold, drop result and total ordering.
// ----------------------------------------------------------------------------
module cic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        dep_valid_i,
  input logic        dep_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [47:0] res_cell_value_i,
  input logic [47:0] res_mass_total_i,
  input logic        res_status_i
);

  // Grid sweep follows reset, so no command is taken right after it
  a_sweep_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !dep_ready_i)
    else $error("command ready right after reset");

  // One command at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_valid_i && dep_ready_i |=> !dep_ready_i)
    else $error("command taken while busy");

  // A dropped deposit reports no cell value
  a_drop_zero_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i |-> res_cell_value_i == 48'd0)
    else $error("dropped deposit with cell value");

  // The running total never goes down
  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && $past(res_valid_i) && $past(rst_ni)
      |-> res_mass_total_i >= $past(res_mass_total_i))
    else $error("mass total decreased");

  // Stalled result beat holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_cell_value_i)
      && $stable(res_mass_total_i) && $stable(res_status_i))
    else $error("stalled result changed");

endmodule

bind cic_mass_deposit_core cic_checker u_cic_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .dep_valid_i      (dep_i.valid),
  .dep_ready_i      (dep_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_cell_value_i (res_o.cell_value),
  .res_mass_total_i (res_o.mass_total),
  .res_status_i     (res_o.status)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the cloud-in-cell mass deposit core
// Drives deposit and read beats through valid/ready channels with random
// gaps and stalls. Each command is run through a local model of the grid and
// the mass total, and every result beat is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;
  import cic_pkg::*;

  localparam int  HALF_PERIOD     = 2;
  localparam int  RESET_CYCLES    = 8;
  localparam int  PHASE_ITEMS     = 90;
  localparam int  RANDOM_PHASES   = 6;
  localparam int  SETTLE_CYCLES   = 4;
  localparam int  TAIL_CYCLES     = 64;
  localparam int  REPORT_LIMIT    = 10;
  // covers the quiet grid sweep after reset
  localparam int  WATCHDOG_LIMIT  = 800000;

  // spare action code, decoded as a total read
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  localparam longint     POS_LO    = -(64'sd1 <<< 31);
  localparam longint     POS_HI    = (64'sd1 <<< 31) - 1;
  localparam longint     CELL_HI   = (64'sd1 <<< 47) - 1;
  localparam longint     CELL_LO   = -(64'sd1 <<< 47);
  localparam bit [63:0]  TOTAL_MAX = 64'hFFFF_FFFF_FFFF;
  localparam bit [REG_W-1:0] REG_MAX = 31'h7FFF_FFFF;

  typedef logic [GRID_LOG2-1:0] cidx_t;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [MASS_W-1:0] mass;
    logic [MASS_W-1:0] weight;
    logic [CIDX_W-1:0] cell_x;
    logic [CIDX_W-1:0] cell_y;
    logic [CIDX_W-1:0] cell_z;
  } command_t;

  typedef struct {
    bit signed [CELL_W-1:0] cell_val;
    bit [CELL_W-1:0]        total;
    bit                     status;
  } outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cic_dep_if dep_bus ();
  cic_res_if res_bus ();
  cic_cfg_if cfg_bus ();

  cic_mass_deposit_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dep_i  (dep_bus.sink),
    .res_o  (res_bus.source),
    .cfg_i  (cfg_bus.sink)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Model state: registers, grid and running total
  bit [REG_W-1:0]         box_len_q      = BOX_LENGTH_RST;
  bit [REG_W-1:0]         cells_per_len_q = CELLS_PER_LEN_RST;
  bit                     weight_on_q    = 1'b0;
  bit signed [CELL_W-1:0] grid_mass [CELL_COUNT];
  bit [63:0]              mass_sum       = '0;

  command_t pending_cmds [$];
  outcome_t due_results  [$];

  int  fail_cnt     = 0;
  int  quiet_cycles = 0;
  int  gap_left     = 0;
  int  stall_left   = 0;
  bit  src_idle_on  = 1'b0;
  bit  snk_idle_on  = 1'b0;
  bit  cmd_fire     = 1'b0;

  // stimulus memory: last deposit position and the cell it lands in
  logic [POS_W-1:0] last_pos [3];
  cidx_t            hot_cell [3];
  bit               have_last = 1'b0;

  // Wrap one coordinate into the box and split it into cell index and fraction
  function automatic bit locate(input logic [POS_W-1:0] p, output cidx_t idx,
                                output bit [63:0] frac);
    longint    x;
    longint    len;
    bit [63:0] g;
    x   = longint'($signed(p));
    len = longint'(box_len_q);
    idx = '0;
    frac = '0;
    if (x < -len || x >= 2 * len) return 1'b0;
    if (x < 0) x += len;
    else if (x >= len) x -= len;
    g    = 64'(x) * 64'(cells_per_len_q);
    idx  = g[32 +: GRID_LOG2];
    frac = 64'(g[31:16]);
    return 1'b1;
  endfunction

  // Add one trilinear share to a cell, saturating
  function automatic void add_share(cidx_t i, cidx_t j, cidx_t k, bit neg, bit [63:0] mag,
                                    bit [63:0] wa, bit [63:0] wb, bit [63:0] wc);
    bit [63:0] w8;
    bit [63:0] share;
    longint    s;
    w8    = (((wa * wb) >> 16) * wc) >> 16;
    share = (mag * w8) >> 16;
    s = longint'(grid_mass[{i, j, k}]) + (neg ? -longint'(share) : longint'(share));
    if (s > CELL_HI) s = CELL_HI;
    if (s < CELL_LO) s = CELL_LO;
    grid_mass[{i, j, k}] = s[CELL_W-1:0];
  endfunction

  // Predict the result of one command and update the model
  function automatic outcome_t deposit_or_read(command_t c);
    outcome_t  r;
    cidx_t     ix, iy, iz, jx, jy, jz;
    bit [63:0] dx, dy, dz, tx, ty, tz, mag, wm;
    bit        okx, oky, okz, neg;
    longint    wl;
    r.cell_val = '0;
    r.status   = 1'b0;
    case (c.action)
      ACT_DEPOSIT: begin
        okx = locate(c.pos_x, ix, dx);
        oky = locate(c.pos_y, iy, dy);
        okz = locate(c.pos_z, iz, dz);
        if (!(okx && oky && okz)) begin
          r.status = 1'b1;
        end else begin
          tx = 64'(ONE_Q16) - dx;
          ty = 64'(ONE_Q16) - dy;
          tz = 64'(ONE_Q16) - dz;
          jx = ix + 1'b1;
          jy = iy + 1'b1;
          jz = iz + 1'b1;
          mag = 64'(c.mass);
          neg = 1'b0;
          if (weight_on_q) begin
            wl  = longint'($signed(c.weight));
            neg = wl < 0;
            wm  = neg ? 64'(-wl) : 64'(wl);
            mag = (64'(c.mass) * wm) >> 16;
          end
          add_share(ix, iy, iz, neg, mag, tx, ty, tz);
          add_share(jx, iy, iz, neg, mag, dx, ty, tz);
          add_share(ix, jy, iz, neg, mag, tx, dy, tz);
          add_share(ix, iy, jz, neg, mag, tx, ty, dz);
          add_share(jx, jy, iz, neg, mag, dx, dy, tz);
          add_share(jx, iy, jz, neg, mag, dx, ty, dz);
          add_share(ix, jy, jz, neg, mag, tx, dy, dz);
          add_share(jx, jy, jz, neg, mag, dx, dy, dz);
          mass_sum += 64'(c.mass);
          if (mass_sum > TOTAL_MAX) mass_sum = TOTAL_MAX;
        end
      end
      ACT_READ_CELL: begin
        r.cell_val = grid_mass[{c.cell_x[GRID_LOG2-1:0], c.cell_y[GRID_LOG2-1:0],
                                c.cell_z[GRID_LOG2-1:0]}];
      end
      default: ;
    endcase
    r.total = mass_sum[CELL_W-1:0];
    return r;
  endfunction

  function automatic command_t mk_cmd(logic [ACT_W-1:0] act, logic [POS_W-1:0] px,
                                      logic [POS_W-1:0] py, logic [POS_W-1:0] pz,
                                      logic [MASS_W-1:0] m, logic [MASS_W-1:0] w,
                                      logic [CIDX_W-1:0] cx, logic [CIDX_W-1:0] cy,
                                      logic [CIDX_W-1:0] cz);
    command_t c;
    c.action = act;
    c.pos_x  = px;
    c.pos_y  = py;
    c.pos_z  = pz;
    c.mass   = m;
    c.weight = w;
    c.cell_x = cx;
    c.cell_y = cy;
    c.cell_z = cz;
    return c;
  endfunction

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Position mostly inside the accepted span, some at its edges, a few anywhere
  function automatic logic [POS_W-1:0] pick_pos();
    longint      len, v;
    int unsigned r;
    len = longint'(box_len_q);
    r   = $urandom_range(99);
    if (r < 6 || len == 0) return $urandom;
    if (r < 18) begin
      case ($urandom_range(5))
        0:       v = -len;
        1:       v = -len - 1;
        2:       v = len - 1;
        3:       v = len;
        4:       v = 2 * len - 1;
        default: v = 2 * len;
      endcase
    end else begin
      v = -len + longint'({$urandom, $urandom} % 64'(3 * len));
    end
    if (v < POS_LO) v = POS_LO;
    if (v > POS_HI) v = POS_HI;
    return v[POS_W-1:0];
  endfunction

  function automatic logic [MASS_W-1:0] pick_mass();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 18) return '1;
    if (r < 50) return $urandom_range(32'h0010_0000);
    return $urandom;
  endfunction

  function automatic logic [MASS_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) begin
      case ($urandom_range(4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0001_0000;
        3:       return 32'hFFFF_0000;
        default: return '0;
      endcase
    end
    if (r < 55) return 32'($urandom_range(262144) - 131072);
    return $urandom;
  endfunction

  // One random command; reads mostly aim at cells near the last deposit
  function automatic command_t random_cmd();
    command_t    c;
    int unsigned r;
    cidx_t       ix, iy, iz;
    bit [63:0]   fr;
    c = mk_cmd(ACT_W'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
               CIDX_W'($urandom), CIDX_W'($urandom), CIDX_W'($urandom));
    r = $urandom_range(99);
    if (r < 55) begin
      c.action = ACT_DEPOSIT;
      if (have_last && $urandom_range(4) == 0) begin
        c.pos_x = last_pos[0];
        c.pos_y = last_pos[1];
        c.pos_z = last_pos[2];
      end else begin
        c.pos_x = pick_pos();
        c.pos_y = pick_pos();
        c.pos_z = pick_pos();
      end
      c.mass   = pick_mass();
      c.weight = pick_weight();
      if (locate(c.pos_x, ix, fr) && locate(c.pos_y, iy, fr) && locate(c.pos_z, iz, fr)) begin
        last_pos = '{c.pos_x, c.pos_y, c.pos_z};
        hot_cell = '{ix, iy, iz};
        have_last = 1'b1;
      end
    end else if (r < 85) begin
      c.action = ACT_READ_CELL;
      if (have_last && $urandom_range(9) < 6) begin
        c.cell_x[GRID_LOG2-1:0] = hot_cell[0] + cidx_t'($urandom_range(1));
        c.cell_y[GRID_LOG2-1:0] = hot_cell[1] + cidx_t'($urandom_range(1));
        c.cell_z[GRID_LOG2-1:0] = hot_cell[2] + cidx_t'($urandom_range(1));
      end
    end else if (r < 95) begin
      c.action = ACT_READ_TOTAL;
    end else begin
      c.action = ACT_SPARE;
    end
    return c;
  endfunction

  // Register write beat, driven on the falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Unused upper data bits are toggled at random
  task automatic set_regs(input bit [REG_W-1:0] box, input bit [REG_W-1:0] cpl, input bit wt);
    write_reg(CFG_BOX_LENGTH, {1'($urandom), box});
    write_reg(CFG_CELLS_PER_LEN, {1'($urandom), cpl});
    write_reg(CFG_APPLY_WEIGHT, {31'($urandom), wt});
  endtask

  // Wait until every command is out and every result is back
  task automatic settle();
    while (pending_cmds.size() != 0 || dep_bus.valid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Command driver: next beat after a handshake, with random gaps
  always @(negedge clk_i) begin
    command_t nxt;
    bit       launch;
    launch = 1'b0;
    if (rst_ni) begin
      if (cmd_fire || !dep_bus.valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          nxt      = pending_cmds.pop_front();
          launch   = 1'b1;
          gap_left = src_idle_on ? pick_gap() : 0;
        end
      end
      if (launch) begin
        dep_bus.valid  <= 1'b1;
        dep_bus.action <= nxt.action;
        dep_bus.pos_x  <= nxt.pos_x;
        dep_bus.pos_y  <= nxt.pos_y;
        dep_bus.pos_z  <= nxt.pos_z;
        dep_bus.mass   <= nxt.mass;
        dep_bus.weight <= nxt.weight;
        dep_bus.cell_x <= nxt.cell_x;
        dep_bus.cell_y <= nxt.cell_y;
        dep_bus.cell_z <= nxt.cell_z;
      end else if (cmd_fire) begin
        dep_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink: ready with random stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
        if (snk_idle_on && $urandom_range(99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Monitor: register writes, result checks, command prediction, watchdog
  always @(posedge clk_i) begin
    command_t got;
    outcome_t want;
    bit       cfg_fire, res_fire, dep_fire;
    cfg_fire = cfg_bus.valid && cfg_bus.ready;
    res_fire = res_bus.valid && res_bus.ready;
    dep_fire = dep_bus.valid && dep_bus.ready;
    cmd_fire <= rst_ni && dep_fire;
    if (rst_ni) begin
      if (cfg_fire) begin
        case (cfg_bus.index)
          CFG_BOX_LENGTH:    box_len_q       = cfg_bus.data[REG_W-1:0];
          CFG_CELLS_PER_LEN: cells_per_len_q = cfg_bus.data[REG_W-1:0];
          CFG_APPLY_WEIGHT:  weight_on_q     = cfg_bus.data[0];
          default: ;
        endcase
      end

      if (res_fire) begin
        if (due_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("%0t: result beat with nothing expected: cell %0d total %0d status %0b",
                     $realtime, res_bus.cell_value, res_bus.mass_total, res_bus.status);
        end else begin
          want = due_results.pop_front();
          if (res_bus.cell_value !== want.cell_val || res_bus.mass_total !== want.total ||
              res_bus.status !== want.status) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
              $display("%0t: mismatch: cell %0d/%0d total %0d/%0d status %0b/%0b (exp/got)",
                       $realtime, want.cell_val, res_bus.cell_value, want.total,
                       res_bus.mass_total, want.status, res_bus.status);
          end
        end
      end

      if (dep_fire) begin
        got = mk_cmd(dep_bus.action, dep_bus.pos_x, dep_bus.pos_y, dep_bus.pos_z,
                     dep_bus.mass, dep_bus.weight, dep_bus.cell_x, dep_bus.cell_y,
                     dep_bus.cell_z);
        due_results.push_back(deposit_or_read(got));
      end

      if (cfg_fire || res_fire || dep_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    dep_bus.valid  = 1'b0;
    dep_bus.action = ACT_DEPOSIT;
    dep_bus.pos_x  = '0;
    dep_bus.pos_y  = '0;
    dep_bus.pos_z  = '0;
    dep_bus.mass   = '0;
    dep_bus.weight = '0;
    dep_bus.cell_x = '0;
    dep_bus.cell_y = '0;
    dep_bus.cell_z = '0;
    res_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_BOX_LENGTH;
    cfg_bus.data   = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: empty grid, wrap at both faces, range edges, drops
    pending_cmds.push_back(mk_cmd(ACT_READ_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ_CELL, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 0, 0, 0, 32'h0001_0000, 32'h8000_0000,
                                  0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ_CELL, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ_CELL, 0, 0, 0, 0, 0, 6'd63, 6'd63, 6'd63));
    pending_cmds.push_back(mk_cmd(ACT_READ_CELL, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 32'hFFFF_0000, 32'h0001_FFFF, 32'h0001_0000,
                                  32'h0003_0000, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 32'hFFFE_FFFF, 0, 0, 32'h0001_0000, 0,
                                  0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 0, 32'h0002_0000, 0, 32'h0001_0000, 0,
                                  0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 0, 0, 32'h8000_0000, 32'h0001_0000, 0,
                                  0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 32'h7FFF_FFFF, 0, 0, 32'h0001_0000, 0,
                                  0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_SPARE, 0, 0, 0, 0, 0, 0, 0, 0));
    settle();

    // Weighting on: drive one cell to the top rail and another to the bottom
    set_regs(BOX_LENGTH_RST, CELLS_PER_LEN_RST, 1'b1);
    repeat (2)
      pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 32'd10240, 32'd10240, 32'd10240,
                                    32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ_CELL, 0, 0, 0, 0, 0, 6'd10, 6'd10, 6'd10));
    repeat (2)
      pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 32'd20480, 32'd20480, 32'd20480,
                                    32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 32'd20480, 32'd20480, 32'd20480,
                                  32'hFFFF_FFFF, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ_CELL, 0, 0, 0, 0, 0, 6'd20, 6'd20, 6'd20));
    pending_cmds.push_back(mk_cmd(ACT_READ_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0));
    settle();

    // Zero box length drops every deposit
    set_regs('0, CELLS_PER_LEN_RST, 1'b0);
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_DEPOSIT, 32'hFFFF_FFFF, 1, 1, 32'h0001_0000, 0,
                                  0, 0, 0));
    pending_cmds.push_back(mk_cmd(ACT_READ_TOTAL, 0, 0, 0, 0, 0, 0, 0, 0));
    settle();

    // Random phases over a spread of geometries
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      bit [REG_W-1:0] box;
      case (ph)
        0: set_regs(BOX_LENGTH_RST, CELLS_PER_LEN_RST, 1'b0);
        1: set_regs(BOX_LENGTH_RST, CELLS_PER_LEN_RST, 1'b1);
        2: set_regs(REG_MAX, 31'd1, 1'b1);
        3: set_regs(31'd1, REG_MAX, 1'b0);
        4: set_regs(REG_W'($urandom_range(REG_MAX, 1)), REG_W'($urandom_range(REG_MAX, 1)),
                    1'($urandom));
        default: begin
          // about one grid across the box
          box = REG_W'($urandom_range(32'h0100_0000, 32'h0000_1000));
          set_regs(box, REG_W'((64'd1 << 38) / box), 1'($urandom));
        end
      endcase
      src_idle_on = (ph == 0) || ($urandom_range(3) != 0);
      snk_idle_on = (ph == 0) || ($urandom_range(3) != 0);
      have_last   = 1'b0;
      repeat (PHASE_ITEMS) pending_cmds.push_back(random_cmd());
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/cic_pkg.sv
src/cic_if.sv
src/cic_mass_deposit_core.sv
src/cic_checker.sv
verif/testbench.sv
